// ===== rtl/core/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared codes, field widths and types of the fit-policy partition allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned FUNC_W     = 1;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned BIU_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  // Fit policy codes; the unused code behaves as first fit.
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

  localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

  // Flags returned by the shared compare unit.
  typedef struct packed {
    logic fits;    // candidate size is at least the request
    logic better;  // candidate beats the current choice under the policy
  } fpa_cmp_t;

endpackage

// ===== rtl/core/fpa_table.sv =====
// ----------------------------------------------------------------------------
// fpa_table
// Free-size table: one write port, one registered read port. Per-entry valid
// bits make entries that were never loaded read as zero after reset.
// ----------------------------------------------------------------------------
module fpa_table #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [$clog2(MAX_BLOCKS)-1:0] waddr_i,
  input  logic [SIZE_BITS-1:0]          wdata_i,
  input  logic [$clog2(MAX_BLOCKS)-1:0] raddr_i,
  output logic [SIZE_BITS-1:0]          rdata_o
);

  logic [SIZE_BITS-1:0]  mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid_q;
  logic [SIZE_BITS-1:0]  rd_data_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_data_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/fpa_alu.sv =====
// ----------------------------------------------------------------------------
// fpa_alu
// Shared compare and subtract unit: tests a candidate size against the
// request and the current choice, and forms the remaining size.
// ----------------------------------------------------------------------------
module fpa_alu
  import fpa_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [SIZE_BITS-1:0] cand_i,
  input  logic [SIZE_BITS-1:0] req_i,
  input  logic [SIZE_BITS-1:0] best_i,
  output fpa_cmp_t             cmp_o,
  output logic [SIZE_BITS-1:0] diff_o
);

  always_comb begin
    cmp_o.fits = (cand_i >= req_i);
    case (mode_i)
      MODE_BEST:  cmp_o.better = (cand_i < best_i);
      MODE_WORST: cmp_o.better = (cand_i > best_i);
      default:    cmp_o.better = 1'b0;
    endcase
  end

  // Wraps modulo the size width.
  assign diff_o = cand_i - req_i;

endmodule

// ===== rtl/core/fit_policy_partition_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator_top
// Results: a load item gives its result in the cycle after it is accepted. An
//   allocate item scans the partitions in use, reading one entry while the
//   previous one is tested, then in the write-back step updates the chosen
//   partition, if any, and registers its result; first fit stops at a hit.
// Throughput: one item at a time; the scan reads one table entry per cycle
//   through the single read port and one shared compare unit.
// Reset: all partitions read as free size zero, fit mode first fit, all
//   sixteen partitions in use.
// ----------------------------------------------------------------------------
module fit_policy_partition_allocator_top
  import fpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [INDEX_W-1:0]    block_index_i,
  input  logic [SIZE_BITS-1:0]  size_value_i,
  // Result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  granted_o,
  output logic [INDEX_W-1:0]    granted_block_o,
  output logic [SIZE_BITS-1:0]  left_over_o
);

  localparam int unsigned AW    = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [MODE_W-1:0]    fit_mode_q;
  logic [BIU_W-1:0]     blocks_in_use_q;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic [CNT_W-1:0]     limit_q, limit_d;
  logic [CNT_W-1:0]     j_q, j_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        k_q, k_d;
  logic                 found_q, found_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0] best_size_q, best_size_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_granted_q, out_granted_d;
  logic [INDEX_W-1:0]   out_block_q, out_block_d;
  logic [SIZE_BITS-1:0] out_left_q, out_left_d;

  logic                 first_mode;
  logic                 out_free;
  logic                 in_acc;
  logic                 issue;
  logic                 eval;
  logic                 take;
  logic                 load_ok;
  logic [AW+INDEX_W-1:0] load_idx_wide;
  logic [AW+INDEX_W-1:0] best_idx_wide;

  logic                 tbl_we;
  logic [AW-1:0]        tbl_waddr;
  logic [SIZE_BITS-1:0] tbl_wdata;
  logic [SIZE_BITS-1:0] tbl_rdata;

  logic [SIZE_BITS-1:0] alu_cand;
  logic [SIZE_BITS-1:0] alu_diff;
  fpa_cmp_t             alu_cmp;

  fpa_table #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // The unit tests table data while scanning and subtracts the request from
  // the chosen partition in the write-back cycle.
  assign alu_cand = (state_q == ST_WRITE) ? best_size_q : tbl_rdata;

  fpa_alu #(
    .SIZE_BITS (SIZE_BITS)
  ) u_alu (
    .mode_i (fit_mode_q),
    .cand_i (alu_cand),
    .req_i  (req_q),
    .best_i (best_size_q),
    .cmp_o  (alu_cmp),
    .diff_o (alu_diff)
  );

  assign first_mode = !(fit_mode_q == MODE_BEST || fit_mode_q == MODE_WORST);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign load_ok       = (int'(block_index_i) < MAX_BLOCKS);
  assign load_idx_wide = {{AW{1'b0}}, block_index_i};
  assign best_idx_wide = {{INDEX_W{1'b0}}, best_idx_q};

  // A read is issued for entry j while the data of entry k, whose read was
  // issued in the previous cycle, is tested. First fit stops once a partition is found.
  assign issue = (state_q == ST_SCAN) && (j_q < limit_q) && !(first_mode && found_q);
  assign eval  = (state_q == ST_SCAN) && pend_q && !(first_mode && found_q);
  assign take  = eval && alu_cmp.fits && (!found_q || alu_cmp.better);

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    limit_d       = limit_q;
    j_d           = j_q;
    pend_d        = 1'b0;
    k_d           = k_q;
    found_d       = found_q;
    best_idx_d    = best_idx_q;
    best_size_d   = best_size_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_granted_d = out_granted_q;
    out_block_d   = out_block_q;
    out_left_d    = out_left_q;
    tbl_we        = 1'b0;
    tbl_waddr     = best_idx_q;
    tbl_wdata     = alu_diff;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_LOAD) begin
            tbl_we        = load_ok;
            tbl_waddr     = load_idx_wide[AW-1:0];
            tbl_wdata     = size_value_i;
            out_valid_d   = 1'b1;
            out_granted_d = 1'b0;
            out_block_d   = block_index_i;
            out_left_d    = load_ok ? size_value_i : '0;
          end else begin
            req_d   = size_value_i;
            j_d     = '0;
            found_d = 1'b0;
            if (int'(blocks_in_use_q) > MAX_BLOCKS) begin
              limit_d = CNT_W'(MAX_BLOCKS);
            end else begin
              limit_d = CNT_W'(blocks_in_use_q);
            end
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          pend_d = 1'b1;
          k_d    = j_q[AW-1:0];
          j_d    = j_q + CNT_W'(1);
        end
        if (take) begin
          found_d     = 1'b1;
          best_idx_d  = k_q;
          best_size_d = tbl_rdata;
        end
        if ((first_mode && found_q) || (!issue && !pend_q)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          tbl_we        = found_q;
          out_valid_d   = 1'b1;
          out_granted_d = found_q;
          out_block_d   = found_q ? best_idx_wide[INDEX_W-1:0] : '0;
          out_left_d    = found_q ? alu_diff : '0;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      pend_q          <= 1'b0;
      found_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      fit_mode_q      <= MODE_FIRST;
      blocks_in_use_q <= BIU_RESET;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FIT_MODE:      fit_mode_q      <= cfg_wdata_i[MODE_W-1:0];
          REG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_wdata_i[BIU_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    limit_q       <= limit_d;
    j_q           <= j_d;
    k_q           <= k_d;
    best_idx_q    <= best_idx_d;
    best_size_q   <= best_size_d;
    out_granted_q <= out_granted_d;
    out_block_q   <= out_block_d;
    out_left_q    <= out_left_d;
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = out_granted_q;
  assign granted_block_o = out_block_q;
  assign left_over_o     = out_left_q;

  // Items enter only between searches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == ST_IDLE))
    else $error("item accepted while a search is running");

  // A pending read always refers to a partition inside the searched range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && pend_q) |-> (CNT_W'(k_q) < limit_q))
    else $error("table read beyond the partitions in use");

  // The chosen partition always holds at least the request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && found_q) |-> (best_size_q >= req_q))
    else $error("chosen partition is smaller than the request");

  // First fit stops scanning as soon as a partition is found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && found_q && first_mode) |=> (state_q == ST_WRITE))
    else $error("first fit kept scanning after a hit");

  // A granted result only ever comes out of the write-back step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_granted_q) |-> ($past(state_q) == ST_WRITE))
    else $error("grant produced outside write-back");

endmodule

// ===== bench/partition_grant_checker.sv =====
// ----------------------------------------------------------------------------
// partition_grant_checker
// Watches the configuration port and both item channels of the partition
// allocator, keeps its own copy of the free size table, predicts the result of
// every accepted item and compares each accepted result against it.
// ----------------------------------------------------------------------------
module partition_grant_checker
  import fpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [INDEX_W-1:0]    block_index_i,
  input  logic [SIZE_BITS-1:0]  size_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  granted_i,
  input  logic [INDEX_W-1:0]    granted_block_i,
  input  logic [SIZE_BITS-1:0]  left_over_i,
  output int                    mismatch_count_o,
  output int                    results_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 granted;
    logic [INDEX_W-1:0]   blk;
    logic [SIZE_BITS-1:0] left;
  } grant_t;

  logic [SIZE_BITS-1:0] part_free_sizes [MAX_BLOCKS];
  logic [MODE_W-1:0]    policy;
  logic [BIU_W-1:0]     parts_in_use;
  grant_t               expected_grants [$];
  int                   mismatches = 0;
  int                   pending = 0;

  assign mismatch_count_o  = mismatches;
  assign results_pending_o = pending;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  // Updates the table copy as the block would and returns the result item.
  function automatic grant_t predict_grant(input logic [FUNC_W-1:0]    fn,
                                           input logic [INDEX_W-1:0]   idx,
                                           input logic [SIZE_BITS-1:0] req);
    grant_t      res;
    int unsigned limit;
    int unsigned j;
    int unsigned chosen;
    bit          found;
    res = '0;
    if (fn == FUNC_LOAD) begin
      res.blk = idx;
      if (idx < MAX_BLOCKS) begin
        part_free_sizes[idx] = req;
        res.left = req;
      end
      return res;
    end
    limit  = (parts_in_use > MAX_BLOCKS) ? MAX_BLOCKS : parts_in_use;
    found  = 1'b0;
    chosen = 0;
    for (j = 0; j < limit; j++) begin
      if (part_free_sizes[j] >= req) begin
        if (!found) begin
          found  = 1'b1;
          chosen = j;
          // Anything other than best or worst fit stops at the first fit.
          if (policy != MODE_BEST && policy != MODE_WORST) break;
        end else if ((policy == MODE_BEST && part_free_sizes[j] < part_free_sizes[chosen]) ||
                     (policy == MODE_WORST && part_free_sizes[j] > part_free_sizes[chosen])) begin
          chosen = j;
        end
      end
    end
    if (found) begin
      part_free_sizes[chosen] = part_free_sizes[chosen] - req;
      res.granted = 1'b1;
      res.blk     = INDEX_W'(chosen);
      res.left    = part_free_sizes[chosen];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      foreach (part_free_sizes[k]) part_free_sizes[k] = '0;
      policy       = MODE_FIRST;
      parts_in_use = BIU_RESET;
      expected_grants.delete();
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FIT_MODE:      policy = cfg_wdata_i[MODE_W-1:0];
          REG_BLOCKS_IN_USE: parts_in_use = cfg_wdata_i[BIU_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("unexpected result granted=%0b block=%0d left=%0d",
                                    granted_i, granted_block_i, left_over_i));
        end else begin
          want = expected_grants.pop_front();
          if (granted_i !== want.granted)
            report_mismatch($sformatf("granted %0b, expected %0b", granted_i, want.granted));
          if (granted_block_i !== want.blk)
            report_mismatch($sformatf("granted_block %0d, expected %0d",
                                      granted_block_i, want.blk));
          if (left_over_i !== want.left)
            report_mismatch($sformatf("left_over %0d, expected %0d", left_over_i, want.left));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_grants.push_back(predict_grant(func_i, block_index_i, size_value_i));
      pending = expected_grants.size();
    end
  end

endmodule

// ===== bench/fit_policy_partition_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator_top_test
// Drives load and allocate items into the allocator under every fit policy
// and several partition counts, with random idling on both channels and a
// long output hold-off, and reports the verdict from the grant checker.
// ----------------------------------------------------------------------------
module fit_policy_partition_allocator_top_test
  import fpa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIZE_BITS   = 16;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS = 70;

  // Indexes past the register list; writes to them must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [FUNC_W-1:0]     func_i;
  logic [INDEX_W-1:0]    block_index_i;
  logic [SIZE_BITS-1:0]  size_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  granted_o;
  logic [INDEX_W-1:0]    granted_block_o;
  logic [SIZE_BITS-1:0]  left_over_o;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  // Raw register data per phase; some mode values rely on masking to 2 bits.
  int phase_mode [NUM_PHASES] = '{0, 1, 30, 31, 5, 2, 0, 2, 1, 0};
  int phase_biu  [NUM_PHASES] = '{16, 16, 16, 16, 1, 31, 0, 20, 8, 16};
  int phase_send [NUM_PHASES] = '{20, 0, 0, 30, 10, 40, 15, 0, 25, 0};
  int phase_recv [NUM_PHASES] = '{20, 30, 0, 10, 40, 0, 15, 35, 25, 0};

  fit_policy_partition_allocator_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .block_index_i  (block_index_i),
    .size_value_i   (size_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_o      (granted_o),
    .granted_block_o(granted_block_o),
    .left_over_o    (left_over_o)
  );

  partition_grant_checker grant_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .func_i           (func_i),
    .block_index_i    (block_index_i),
    .size_value_i     (size_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_i        (granted_o),
    .granted_block_i  (granted_block_o),
    .left_over_i      (left_over_o),
    .mismatch_count_o (mismatches),
    .results_pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Offers one item and returns at the edge that accepts it, then maybe idles.
  task automatic send_item(input logic [FUNC_W-1:0]    fn,
                           input logic [INDEX_W-1:0]   idx,
                           input logic [SIZE_BITS-1:0] sz);
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    block_index_i <= idx;
    size_value_i  <= sz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_item();
    logic [SIZE_BITS-1:0] sz;
    if ($urandom_range(0, 99) < 35) begin
      case ($urandom_range(0, 9))
        0:       sz = '0;
        1:       sz = '1;
        2, 3, 4: sz = SIZE_BITS'($urandom_range(0, 2000));
        default: sz = SIZE_BITS'($urandom());
      endcase
      send_item(FUNC_LOAD, INDEX_W'($urandom_range(0, 15)), sz);
    end else begin
      case ($urandom_range(0, 9))
        0:       sz = '0;
        1:       sz = '1;
        2:       sz = SIZE_BITS'($urandom());
        default: sz = SIZE_BITS'($urandom_range(1, 600));
      endcase
      send_item(FUNC_ALLOC, INDEX_W'($urandom()), sz);
    end
  endtask

  // Drops valid and waits until every outstanding item has its result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_FIT_MODE;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    func_i        <= FUNC_LOAD;
    block_index_i <= '0;
    size_value_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset: a zero request fits, anything else does not.
    send_item(FUNC_ALLOC, 4'd9, 16'd0);
    send_item(FUNC_ALLOC, 4'd0, 16'd1);
    send_item(FUNC_LOAD, 4'd15, 16'hFFFF);
    send_item(FUNC_LOAD, 4'd0, 16'd0);
    send_item(FUNC_LOAD, 4'd3, 16'd300);
    send_item(FUNC_LOAD, 4'd5, 16'd100);
    send_item(FUNC_LOAD, 4'd7, 16'd100);
    send_item(FUNC_LOAD, 4'd10, 16'hFFFE);
    send_item(FUNC_ALLOC, 4'd0, 16'hFFFF);
    send_item(FUNC_ALLOC, 4'd15, 16'd100);
    send_item(FUNC_ALLOC, 4'd0, 16'd150);
    drain_results();

    // Best fit with a tie between partitions holding the same size.
    write_reg(REG_FIT_MODE, MODE_BEST);
    send_item(FUNC_ALLOC, 4'd0, 16'd90);
    send_item(FUNC_ALLOC, 4'd0, 16'd60);
    drain_results();

    write_reg(REG_FIT_MODE, MODE_WORST);
    send_item(FUNC_ALLOC, 4'd0, 16'd1000);
    send_item(FUNC_ALLOC, 4'd0, 16'd0);
    drain_results();

    // The unused policy code falls back to first fit.
    write_reg(REG_FIT_MODE, 3);
    send_item(FUNC_ALLOC, 4'd0, 16'd10);
    drain_results();

    write_reg(REG_BLOCKS_IN_USE, 1);
    send_item(FUNC_ALLOC, 4'd0, 16'd1);
    drain_results();
    write_reg(REG_BLOCKS_IN_USE, 0);
    send_item(FUNC_ALLOC, 4'd0, 16'd0);
    drain_results();
    write_reg(REG_BLOCKS_IN_USE, 31);
    write_reg(REG_SPARE_A, 31);
    write_reg(REG_SPARE_B, 31);
    send_item(FUNC_ALLOC, 4'd0, 16'd0);
    send_item(FUNC_LOAD, 4'd15, 16'h8000);
    send_item(FUNC_LOAD, 4'd0, 16'hFFFF);
    send_item(FUNC_ALLOC, 4'd0, 16'h7FFF);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_FIT_MODE, phase_mode[p]);
      write_reg(REG_BLOCKS_IN_USE, phase_biu[p]);
      send_idle_pct = phase_send[p];
      recv_idle_pct = phase_recv[p];
      // One phase holds the result side off while items keep coming.
      if (p == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_item();
      drain_results();
    end

    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fpa_pkg.sv
rtl/core/fpa_table.sv
rtl/core/fpa_alu.sv
rtl/core/fit_policy_partition_allocator_top.sv
bench/partition_grant_checker.sv
bench/fit_policy_partition_allocator_top_test.sv
